// File: src/cpop_pkg.sv
// ----------------------------------------------------------------------------
// cpop_pkg: shared types and constants of the cavity population update unit
// Holds the population geometry, the IEEE double constants, operation codes,
// the state types and the double unpack and quiet helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cpop_pkg;

  // Population geometry.
  localparam int POP_SIZE  = 1024;
  localparam int IDX_W     = 10;
  localparam int MAX_NB    = 8;
  localparam int NB_IDX_W  = 3;
  localparam int CNT_W     = 4;
  localparam int DBL_W     = 64;
  localparam int EXP_W     = 14;
  localparam int XW        = 108;

  // Iteration counts of the shared floating-point unit.
  localparam int MUL_STEPS = 4;
  localparam int DIV_BITS  = 57;

  // Double constants.
  localparam logic [DBL_W-1:0] C_LOAD_IMAG = 64'h3FB9_9999_9999_999A;
  localparam logic [DBL_W-1:0] C_POS_INF   = 64'h7FF0_0000_0000_0000;
  localparam logic [DBL_W-1:0] C_DEF_NAN   = 64'hFFF8_0000_0000_0000;

  // Commands carried by an input item.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BROADENING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NB_COUNT   = 2'd2;

  // Floating-point operations.
  typedef enum logic [1:0] {
    FOP_ADD,
    FOP_SUB,
    FOP_MUL,
    FOP_DIV
  } fp_op_t;

  // Request from the sequencer to the floating-point unit.
  typedef struct packed {
    logic   start;
    fp_op_t op;
  } fpu_req_t;

  // Floating-point unit states.
  typedef enum logic [2:0] {
    F_IDLE,
    F_ALIGN,
    F_MUL,
    F_DNORM,
    F_DIV,
    F_NORM,
    F_ROUND
  } fpu_state_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRE,
    ST_NB_RD,
    ST_NB_SRE,
    ST_NB_SIM,
    ST_DRE,
    ST_DIM,
    ST_DSUM,
    ST_DCHK,
    ST_QRE,
    ST_QIM,
    ST_TGT_RD,
    ST_TOT_SUB,
    ST_TOT_ADD,
    ST_WB,
    ST_CLEAR
  } seq_state_t;

  // Unpacked double: value is mant * 2^expo for finite operands.
  typedef struct packed {
    logic             sign;
    logic             nan;
    logic             inf;
    logic             zero;
    logic [52:0]      mant;
    logic [EXP_W-1:0] expo;
  } dbl_t;

  function automatic dbl_t dbl_unpack(input logic [DBL_W-1:0] v);
    dbl_t u;
    u.sign = v[63];
    u.nan  = (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
    u.inf  = (v[62:52] == 11'h7FF) && (v[51:0] == 52'd0);
    u.zero = (v[62:0] == 63'd0);
    u.mant = {(v[62:52] != 11'd0), v[51:0]};
    if (v[62:52] == 11'd0) begin
      u.expo = 14'd0 - 14'd1074;
    end else begin
      u.expo = {3'b000, v[62:52]} - 14'd1075;
    end
    return u;
  endfunction

  // A NaN operand passes through with its quiet bit set.
  function automatic logic [DBL_W-1:0] dbl_quiet(input logic [DBL_W-1:0] v);
    return {v[63:52], 1'b1, v[50:0]};
  endfunction

endpackage

`default_nettype wire

// File: src/cpop_ram.sv
// ----------------------------------------------------------------------------
// cpop_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cpop_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: src/cpop_fpu.sv
// ----------------------------------------------------------------------------
// cpop_fpu: iterative IEEE double add, subtract, multiply and divide
// Round to nearest even with subnormals. Multiplication takes 16-bit digits,
// division one quotient bit a cycle, normalization one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpop_fpu (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cpop_pkg::fpu_req_t req,
  input  wire logic [63:0]        opa,
  input  wire logic [63:0]        opb,
  output logic                    done,
  output logic [63:0]             result
);

  localparam logic signed [cpop_pkg::EXP_W-1:0] EXP_MIN  = -14'sd1077;
  localparam logic signed [cpop_pkg::EXP_W-1:0] EXP_BIAS = 14'sd1078;

  cpop_pkg::fpu_state_t fst_r, fst_nxt;
  logic                 done_r, done_nxt;
  logic [63:0]          res_r, res_nxt;
  logic                 sa_r, sa_nxt, sb_r, sb_nxt, sign_r, sign_nxt;
  logic signed [cpop_pkg::EXP_W-1:0] ea_r, ea_nxt, eb_r, eb_nxt, exp_r, exp_nxt;
  logic [52:0]          ma_r, ma_nxt;
  logic [63:0]          mb_r, mb_nxt;
  logic [cpop_pkg::XW-1:0] x_r, x_nxt;
  logic                 sticky_r, sticky_nxt;
  logic [53:0]          rem_r, rem_nxt;
  logic [5:0]           cnt_r, cnt_nxt;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r  <= cpop_pkg::F_IDLE;
      done_r <= 1'b0;
    end else begin
      fst_r  <= fst_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    sa_r     <= sa_nxt;
    sb_r     <= sb_nxt;
    sign_r   <= sign_nxt;
    ea_r     <= ea_nxt;
    eb_r     <= eb_nxt;
    exp_r    <= exp_nxt;
    ma_r     <= ma_nxt;
    mb_r     <= mb_nxt;
    x_r      <= x_nxt;
    sticky_r <= sticky_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
  end

  // Next state and datapath.
  always_comb begin
    cpop_pkg::dbl_t ua;
    cpop_pkg::dbl_t ub;
    logic        sbe;
    logic        sx;
    logic        swap;
    logic signed [cpop_pkg::EXP_W-1:0] eg;
    logic signed [cpop_pkg::EXP_W-1:0] el;
    logic signed [cpop_pkg::EXP_W-1:0] dexp;
    logic [52:0] mg;
    logic [52:0] ml;
    logic        sg;
    logic        sl;
    logic [5:0]  sh;
    logic [118:0] wide;
    logic [55:0] xg;
    logic [55:0] xl;
    logic        st;
    logic [56:0] dif;
    logic [56:0] sum;
    logic        ge;
    logic [52:0] diffrem;
    logic [12:0] e_pre;
    logic        inc;
    logic [64:0] packed_v;

    fst_nxt    = fst_r;
    done_nxt   = 1'b0;
    res_nxt    = res_r;
    sa_nxt     = sa_r;
    sb_nxt     = sb_r;
    sign_nxt   = sign_r;
    ea_nxt     = ea_r;
    eb_nxt     = eb_r;
    exp_nxt    = exp_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    x_nxt      = x_r;
    sticky_nxt = sticky_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;

    ua       = cpop_pkg::dbl_unpack(opa);
    ub       = cpop_pkg::dbl_unpack(opb);
    sbe      = ub.sign ^ (req.op == cpop_pkg::FOP_SUB);
    sx       = ua.sign ^ ub.sign;
    swap     = eb_r > ea_r;
    eg       = swap ? eb_r : ea_r;
    el       = swap ? ea_r : eb_r;
    mg       = swap ? mb_r[52:0] : ma_r;
    ml       = swap ? ma_r : mb_r[52:0];
    sg       = swap ? sb_r : sa_r;
    sl       = swap ? sa_r : sb_r;
    dexp     = eg - el;
    sh       = (dexp > 14'sd63) ? 6'd63 : dexp[5:0];
    wide     = {ml, 66'd0} >> sh;
    xg       = {mg, 3'b000};
    xl       = wide[118:63];
    st       = |wide[62:0];
    dif      = {1'b0, xg} - {1'b0, xl} - {56'd0, st};
    sum      = 57'd0;
    ge       = rem_r >= {1'b0, mb_r[52:0]};
    diffrem  = ge ? 53'(rem_r - {1'b0, mb_r[52:0]}) : rem_r[52:0];
    e_pre    = x_r[55] ? 13'(exp_r + EXP_BIAS) : 13'd0;
    inc      = x_r[2] & (x_r[1] | x_r[0] | sticky_r | x_r[3]);
    packed_v = {e_pre, x_r[54:3]} + 65'(inc);

    unique case (fst_r)
      // Accept an operation; settle NaN, inf and mul/div zero cases at once.
      cpop_pkg::F_IDLE: begin
        if (req.start) begin
          sa_nxt     = ua.sign;
          sb_nxt     = (req.op == cpop_pkg::FOP_SUB) ? sbe : ub.sign;
          ea_nxt     = ua.expo;
          eb_nxt     = ub.expo;
          ma_nxt     = ua.mant;
          mb_nxt     = {11'd0, ub.mant};
          x_nxt      = '0;
          sticky_nxt = 1'b0;
          cnt_nxt    = 6'd0;
          if (ua.nan) begin
            res_nxt  = cpop_pkg::dbl_quiet(opa);
            done_nxt = 1'b1;
          end else if (ub.nan) begin
            res_nxt  = cpop_pkg::dbl_quiet(opb);
            done_nxt = 1'b1;
          end else begin
            unique case (req.op) inside
              cpop_pkg::FOP_ADD, cpop_pkg::FOP_SUB: begin
                if (ua.inf && ub.inf) begin
                  res_nxt  = (ua.sign == sbe) ? opa : cpop_pkg::C_DEF_NAN;
                  done_nxt = 1'b1;
                end else if (ua.inf) begin
                  res_nxt  = {ua.sign, cpop_pkg::C_POS_INF[62:0]};
                  done_nxt = 1'b1;
                end else if (ub.inf) begin
                  res_nxt  = {sbe, cpop_pkg::C_POS_INF[62:0]};
                  done_nxt = 1'b1;
                end else begin
                  fst_nxt = cpop_pkg::F_ALIGN;
                end
              end
              cpop_pkg::FOP_MUL: begin
                if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
                  res_nxt  = cpop_pkg::C_DEF_NAN;
                  done_nxt = 1'b1;
                end else if (ua.inf || ub.inf) begin
                  res_nxt  = {sx, cpop_pkg::C_POS_INF[62:0]};
                  done_nxt = 1'b1;
                end else if (ua.zero || ub.zero) begin
                  res_nxt  = {sx, 63'd0};
                  done_nxt = 1'b1;
                end else begin
                  fst_nxt = cpop_pkg::F_MUL;
                end
              end
              cpop_pkg::FOP_DIV: begin
                if ((ua.inf && ub.inf) || (ua.zero && ub.zero)) begin
                  res_nxt  = cpop_pkg::C_DEF_NAN;
                  done_nxt = 1'b1;
                end else if (ua.inf || ub.zero) begin
                  res_nxt  = {sx, cpop_pkg::C_POS_INF[62:0]};
                  done_nxt = 1'b1;
                end else if (ub.inf || ua.zero) begin
                  res_nxt  = {sx, 63'd0};
                  done_nxt = 1'b1;
                end else begin
                  fst_nxt = cpop_pkg::F_DNORM;
                end
              end
              default: ;
            endcase
          end
        end
      end

      // Align the smaller operand with guard bits and a sticky bit, then add.
      cpop_pkg::F_ALIGN: begin
        if (sg == sl) begin
          sum      = {1'b0, xg} + {1'b0, xl};
          sign_nxt = sg;
        end else if (dif[56]) begin
          sum      = 57'd0 - dif;
          sign_nxt = sl;
        end else begin
          sum      = dif;
          sign_nxt = (dif == 57'd0 && !st) ? 1'b0 : sg;
        end
        x_nxt      = cpop_pkg::XW'(sum);
        sticky_nxt = st;
        exp_nxt    = eg - 14'sd3;
        fst_nxt    = cpop_pkg::F_NORM;
      end

      // Multiply one 16-bit digit of the second mantissa per cycle.
      cpop_pkg::F_MUL: begin
        x_nxt   = (x_r << 16) + cpop_pkg::XW'(ma_r * mb_r[63:48]);
        mb_nxt  = mb_r << 16;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(cpop_pkg::MUL_STEPS - 1)) begin
          exp_nxt  = ea_r + eb_r;
          sign_nxt = sa_r ^ sb_r;
          fst_nxt  = cpop_pkg::F_NORM;
        end
      end

      // Bring subnormal mantissas to full length before dividing.
      cpop_pkg::F_DNORM: begin
        if (!ma_r[52]) begin
          ma_nxt = ma_r << 1;
          ea_nxt = ea_r - 14'sd1;
        end
        if (!mb_r[52]) begin
          mb_nxt = mb_r << 1;
          eb_nxt = eb_r - 14'sd1;
        end
        if (ma_r[52] && mb_r[52]) begin
          rem_nxt = {1'b0, ma_r};
          cnt_nxt = 6'(cpop_pkg::DIV_BITS - 1);
          x_nxt   = '0;
          fst_nxt = cpop_pkg::F_DIV;
        end
      end

      // Restoring division, one quotient bit per cycle.
      cpop_pkg::F_DIV: begin
        rem_nxt = {diffrem, 1'b0};
        x_nxt   = {x_r[cpop_pkg::XW-2:0], ge};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          sticky_nxt = |diffrem;
          exp_nxt    = ea_r - eb_r - 14'(cpop_pkg::DIV_BITS - 1);
          sign_nxt   = sa_r ^ sb_r;
          fst_nxt    = cpop_pkg::F_NORM;
        end
      end

      // Move the leading one to bit 55, or right for subnormal results.
      cpop_pkg::F_NORM: begin
        if (x_r == '0) begin
          fst_nxt = cpop_pkg::F_ROUND;
        end else if ((|x_r[cpop_pkg::XW-1:56]) || (exp_r < EXP_MIN)) begin
          sticky_nxt = sticky_r | x_r[0];
          x_nxt      = x_r >> 1;
          exp_nxt    = exp_r + 14'sd1;
        end else if (!x_r[55] && (exp_r > EXP_MIN)) begin
          x_nxt   = x_r << 1;
          exp_nxt = exp_r - 14'sd1;
        end else begin
          fst_nxt = cpop_pkg::F_ROUND;
        end
      end

      // Round to nearest even; a carry may step into the exponent.
      cpop_pkg::F_ROUND: begin
        if (packed_v[64:52] >= 13'd2047) begin
          res_nxt = {sign_r, cpop_pkg::C_POS_INF[62:0]};
        end else begin
          res_nxt = {sign_r, packed_v[62:0]};
        end
        done_nxt = 1'b1;
        fst_nxt  = cpop_pkg::F_IDLE;
      end

      default: fst_nxt = cpop_pkg::F_IDLE;
    endcase
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

`default_nettype wire

// File: src/cavity_population_update_unit.sv
// ----------------------------------------------------------------------------
// cavity_population_update_unit: cavity Green's function population keeper
// Stores 1024 complex doubles and updates one entry per item.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid / in_stall. A load item stores value + 0.1i
// at entry_index; an update item forms (W - energy) - i*epsilon, subtracts up
// to eight neighbor entries and stores the complex reciprocal. Each item gives
// one result on out_valid / out_stall: the new entry and the running sum of
// all imaginary parts. The user must write registers on cfg_valid /
// cfg_ready only while no item is in flight; the block itself does not
// enforce it, and cfg_ready is always high. One item is worked at a time
// through a single shared floating-point unit; in_stall stays high until
// the result is in the output register. Each floating-point operation that
// is not settled on acceptance runs the one-bit normalize loop, and a
// divide also the one-bit divide loop. A load takes two operations, a
// subtraction and an addition. An update with n neighbors takes 2n + 8
// operations, or 2n + 6 for a zero divisor. The output register frees the
// input side: a new item is accepted while a result still waits; the next
// result waits for out_stall. Reset clears the control state and the
// running sum, loads the register defaults and runs a pass that writes zero
// to every entry, with in_stall high, before the first item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cavity_population_update_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [9:0]  in_entry_index,
  input  wire logic [63:0] in_value_bits,
  input  wire logic [9:0]  in_neighbor_a,
  input  wire logic [9:0]  in_neighbor_b,
  input  wire logic [9:0]  in_neighbor_c,
  input  wire logic [9:0]  in_neighbor_d,
  input  wire logic [9:0]  in_neighbor_e,
  input  wire logic [9:0]  in_neighbor_f,
  input  wire logic [9:0]  in_neighbor_g,
  input  wire logic [9:0]  in_neighbor_h,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_new_real_bits,
  output logic [63:0]      out_new_imag_bits,
  output logic [63:0]      out_imag_total_bits,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  cpop_pkg::seq_state_t state_r, state_nxt;
  logic                 busy_r, busy_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [63:0]          total_r, total_nxt;
  logic [63:0]          energy_r, energy_nxt;
  logic [63:0]          eps_r, eps_nxt;
  logic [cpop_pkg::CNT_W-1:0] ncount_r, ncount_nxt;
  logic [cpop_pkg::IDX_W-1:0] clr_r, clr_nxt;

  logic [cpop_pkg::IDX_W-1:0]    target_r, target_nxt;
  logic [63:0]                   value_r, value_nxt;
  logic [cpop_pkg::IDX_W-1:0]    nb_r [cpop_pkg::MAX_NB];
  logic [cpop_pkg::IDX_W-1:0]    nb_nxt [cpop_pkg::MAX_NB];
  logic [cpop_pkg::NB_IDX_W-1:0] k_r, k_nxt;
  logic [63:0] s_re_r, s_re_nxt, s_im_r, s_im_nxt;
  logic [63:0] d_r, d_nxt, t_r, t_nxt;
  logic [63:0] new_re_r, new_re_nxt, new_im_r, new_im_nxt;
  logic [63:0] out_re_r, out_re_nxt, out_im_r, out_im_nxt, out_tot_r, out_tot_nxt;

  cpop_pkg::fpu_req_t         fpu_req;
  logic [63:0]                fpu_a, fpu_b, fpu_res;
  logic                       fpu_done;
  logic                       ram_wr_en, ram_rd_en;
  logic [cpop_pkg::IDX_W-1:0] ram_wr_addr;
  logic [127:0]               ram_wr_data;
  logic [cpop_pkg::IDX_W-1:0] ram_rd_addr;
  logic [127:0]               ram_rd_data;
  logic [63:0]                rd_re, rd_im;
  logic [cpop_pkg::CNT_W-1:0] cnt_eff;

  // Shared floating-point unit.
  cpop_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (fpu_req),
    .opa    (fpu_a),
    .opb    (fpu_b),
    .done   (fpu_done),
    .result (fpu_res)
  );

  // Population memory: real part in the upper half, imaginary in the lower.
  cpop_ram #(
    .WIDTH (128),
    .DEPTH (cpop_pkg::POP_SIZE)
  ) u_pop_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_re   = ram_rd_data[127:64];
  assign rd_im   = ram_rd_data[63:0];
  assign cnt_eff = (ncount_r > cpop_pkg::CNT_W'(cpop_pkg::MAX_NB)) ?
                   cpop_pkg::CNT_W'(cpop_pkg::MAX_NB) : ncount_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpop_pkg::ST_CLEAR;
      clr_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= 64'd0;
      energy_r    <= 64'd0;
      eps_r       <= 64'd0;
      ncount_r    <= 4'd2;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      energy_r    <= energy_nxt;
      eps_r       <= eps_nxt;
      ncount_r    <= ncount_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    target_r  <= target_nxt;
    value_r   <= value_nxt;
    nb_r      <= nb_nxt;
    k_r       <= k_nxt;
    s_re_r    <= s_re_nxt;
    s_im_r    <= s_im_nxt;
    d_r       <= d_nxt;
    t_r       <= t_nxt;
    new_re_r  <= new_re_nxt;
    new_im_r  <= new_im_nxt;
    out_re_r  <= out_re_nxt;
    out_im_r  <= out_im_nxt;
    out_tot_r <= out_tot_nxt;
  end

  // Sequencer: next state, floating-point calls and memory access.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && out_stall;
    total_nxt     = total_r;
    energy_nxt    = energy_r;
    eps_nxt       = eps_r;
    ncount_nxt    = ncount_r;
    target_nxt    = target_r;
    value_nxt     = value_r;
    nb_nxt        = nb_r;
    k_nxt         = k_r;
    s_re_nxt      = s_re_r;
    s_im_nxt      = s_im_r;
    d_nxt         = d_r;
    t_nxt         = t_r;
    new_re_nxt    = new_re_r;
    new_im_nxt    = new_im_r;
    out_re_nxt    = out_re_r;
    out_im_nxt    = out_im_r;
    out_tot_nxt   = out_tot_r;

    fpu_req.start = 1'b0;
    fpu_req.op    = cpop_pkg::FOP_ADD;
    fpu_a         = s_re_r;
    fpu_b         = s_re_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = target_r;
    ram_wr_data   = {new_re_r, new_im_r};
    ram_rd_en     = 1'b0;
    ram_rd_addr   = target_r;

    // Configuration writes.
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cpop_pkg::CFG_ENERGY:     energy_nxt = cfg_data;
        cpop_pkg::CFG_BROADENING: eps_nxt    = cfg_data;
        cpop_pkg::CFG_NB_COUNT:   ncount_nxt = cfg_data[cpop_pkg::CNT_W-1:0];
        default: ;
      endcase
    end

    // States that call the floating-point unit start it once and wait.
    if (!busy_r) begin
      fpu_req.start = (state_r == cpop_pkg::ST_SRE)     ||
                      (state_r == cpop_pkg::ST_NB_SRE)  ||
                      (state_r == cpop_pkg::ST_NB_SIM)  ||
                      (state_r == cpop_pkg::ST_DRE)     ||
                      (state_r == cpop_pkg::ST_DIM)     ||
                      (state_r == cpop_pkg::ST_DSUM)    ||
                      (state_r == cpop_pkg::ST_QRE)     ||
                      (state_r == cpop_pkg::ST_QIM)     ||
                      (state_r == cpop_pkg::ST_TOT_SUB) ||
                      (state_r == cpop_pkg::ST_TOT_ADD);
      busy_nxt = fpu_req.start;
    end else if (fpu_done) begin
      busy_nxt = 1'b0;
    end

    unique case (state_r)
      // After reset every entry is written to zero, one per cycle.
      cpop_pkg::ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_r;
        ram_wr_data = '0;
        clr_nxt     = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = cpop_pkg::ST_IDLE;
        end
      end

      // Take an item and fix the starting sums.
      cpop_pkg::ST_IDLE: begin
        if (in_valid) begin
          target_nxt = in_entry_index;
          value_nxt  = in_value_bits;
          nb_nxt[0]  = in_neighbor_a;
          nb_nxt[1]  = in_neighbor_b;
          nb_nxt[2]  = in_neighbor_c;
          nb_nxt[3]  = in_neighbor_d;
          nb_nxt[4]  = in_neighbor_e;
          nb_nxt[5]  = in_neighbor_f;
          nb_nxt[6]  = in_neighbor_g;
          nb_nxt[7]  = in_neighbor_h;
          k_nxt      = '0;
          s_im_nxt   = {~eps_r[63], eps_r[62:0]};
          if (in_cmd == cpop_pkg::CMD_LOAD) begin
            new_re_nxt = in_value_bits;
            new_im_nxt = cpop_pkg::C_LOAD_IMAG;
            state_nxt  = cpop_pkg::ST_TGT_RD;
          end else begin
            state_nxt = cpop_pkg::ST_SRE;
          end
        end
      end

      // Real part starts as W minus energy.
      cpop_pkg::ST_SRE: begin
        fpu_req.op = cpop_pkg::FOP_SUB;
        fpu_a      = value_r;
        fpu_b      = energy_r;
        if (busy_r && fpu_done) begin
          s_re_nxt  = fpu_res;
          state_nxt = (cnt_eff == '0) ? cpop_pkg::ST_DRE : cpop_pkg::ST_NB_RD;
        end
      end

      // Fetch the next neighbor entry.
      cpop_pkg::ST_NB_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = nb_r[k_r];
        state_nxt   = cpop_pkg::ST_NB_SRE;
      end

      cpop_pkg::ST_NB_SRE: begin
        fpu_req.op = cpop_pkg::FOP_SUB;
        fpu_a      = s_re_r;
        fpu_b      = rd_re;
        if (busy_r && fpu_done) begin
          s_re_nxt  = fpu_res;
          state_nxt = cpop_pkg::ST_NB_SIM;
        end
      end

      cpop_pkg::ST_NB_SIM: begin
        fpu_req.op = cpop_pkg::FOP_SUB;
        fpu_a      = s_im_r;
        fpu_b      = rd_im;
        if (busy_r && fpu_done) begin
          s_im_nxt = fpu_res;
          k_nxt    = k_r + 1'b1;
          if (({1'b0, k_r} + 4'd1) == cnt_eff) begin
            state_nxt = cpop_pkg::ST_DRE;
          end else begin
            state_nxt = cpop_pkg::ST_NB_RD;
          end
        end
      end

      // Squared magnitude of the sum.
      cpop_pkg::ST_DRE: begin
        fpu_req.op = cpop_pkg::FOP_MUL;
        fpu_a      = s_re_r;
        fpu_b      = s_re_r;
        if (busy_r && fpu_done) begin
          d_nxt     = fpu_res;
          state_nxt = cpop_pkg::ST_DIM;
        end
      end

      cpop_pkg::ST_DIM: begin
        fpu_req.op = cpop_pkg::FOP_MUL;
        fpu_a      = s_im_r;
        fpu_b      = s_im_r;
        if (busy_r && fpu_done) begin
          t_nxt     = fpu_res;
          state_nxt = cpop_pkg::ST_DSUM;
        end
      end

      cpop_pkg::ST_DSUM: begin
        fpu_req.op = cpop_pkg::FOP_ADD;
        fpu_a      = d_r;
        fpu_b      = t_r;
        if (busy_r && fpu_done) begin
          d_nxt     = fpu_res;
          state_nxt = cpop_pkg::ST_DCHK;
        end
      end

      // A zero divisor of either sign gives plus infinity and zero.
      cpop_pkg::ST_DCHK: begin
        if (d_r[62:0] == 63'd0) begin
          new_re_nxt = cpop_pkg::C_POS_INF;
          new_im_nxt = 64'd0;
          state_nxt  = cpop_pkg::ST_TGT_RD;
        end else begin
          state_nxt = cpop_pkg::ST_QRE;
        end
      end

      // Reciprocal: conj(S) / |S|^2.
      cpop_pkg::ST_QRE: begin
        fpu_req.op = cpop_pkg::FOP_DIV;
        fpu_a      = s_re_r;
        fpu_b      = d_r;
        if (busy_r && fpu_done) begin
          new_re_nxt = fpu_res;
          state_nxt  = cpop_pkg::ST_QIM;
        end
      end

      cpop_pkg::ST_QIM: begin
        fpu_req.op = cpop_pkg::FOP_DIV;
        fpu_a      = {~s_im_r[63], s_im_r[62:0]};
        fpu_b      = d_r;
        if (busy_r && fpu_done) begin
          new_im_nxt = fpu_res;
          state_nxt  = cpop_pkg::ST_TGT_RD;
        end
      end

      // Fetch the old value of the target entry.
      cpop_pkg::ST_TGT_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = target_r;
        state_nxt   = cpop_pkg::ST_TOT_SUB;
      end

      // Running sum: old imaginary part out, new one in.
      cpop_pkg::ST_TOT_SUB: begin
        fpu_req.op = cpop_pkg::FOP_SUB;
        fpu_a      = total_r;
        fpu_b      = rd_im;
        if (busy_r && fpu_done) begin
          total_nxt = fpu_res;
          state_nxt = cpop_pkg::ST_TOT_ADD;
        end
      end

      cpop_pkg::ST_TOT_ADD: begin
        fpu_req.op = cpop_pkg::FOP_ADD;
        fpu_a      = total_r;
        fpu_b      = new_im_r;
        if (busy_r && fpu_done) begin
          total_nxt = fpu_res;
          state_nxt = cpop_pkg::ST_WB;
        end
      end

      // Write the entry back and hand the result to the output register.
      cpop_pkg::ST_WB: begin
        if (!out_valid_r || !out_stall) begin
          ram_wr_en     = 1'b1;
          out_valid_nxt = 1'b1;
          out_re_nxt    = new_re_r;
          out_im_nxt    = new_im_r;
          out_tot_nxt   = total_r;
          state_nxt     = cpop_pkg::ST_IDLE;
        end
      end

      default: state_nxt = cpop_pkg::ST_IDLE;
    endcase
  end

  assign in_stall            = (state_r != cpop_pkg::ST_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_new_real_bits   = out_re_r;
  assign out_new_imag_bits   = out_im_r;
  assign out_imag_total_bits = out_tot_r;

endmodule

`default_nettype wire
